// File: sv/tpdeq_pkg.sv
// Shared types, codes and constants for the touch packet decoder and event queue.
package tpdeq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 14;
    localparam int RAW_W       = 14;
    localparam int POS_W       = 13;
    localparam int ID_W        = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 14'd240;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 14'd208;

    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] KEEP_BYTE  = 8'hFF;

    typedef enum logic [1:0] {
        CMD_BYTE     = 2'd0,
        CMD_LINE_ERR = 2'd1,
        CMD_POP      = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DOWN = 2'd0,
        KIND_MOVE = 2'd1,
        KIND_UP   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_X_HI  = 3'd1,
        PH_X_LO  = 3'd2,
        PH_Y_HI  = 3'd3,
        PH_Y_LO  = 3'd4,
        PH_PRESS = 3'd5
    } t_phase;

    typedef struct packed {
        logic [ID_W-1:0]  touch_id;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             position_valid;
        t_kind            event_kind;
    } t_event;

    typedef struct packed {
        logic   wr_en;
        logic   evict;
        t_event entry;
    } t_wr_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: sv/tpdeq_decoder.sv
// Packet parser and touch event builder with its contact tracking state.
module tpdeq_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_byte_go,
    input  logic                                i_err_go,
    input  logic [7:0]                          i_rx_byte,
    input  logic [tpdeq_pkg::CFG_DATA_W-1:0]    i_screen_width,
    input  logic [tpdeq_pkg::CFG_DATA_W-1:0]    i_screen_height,
    input  tpdeq_pkg::t_q_status                i_status,
    output tpdeq_pkg::t_wr_req                  o_wr_req
);

    tpdeq_pkg::t_phase              r_phase, n_phase;
    logic [tpdeq_pkg::RAW_W-1:0]    r_raw_x, n_raw_x;
    logic [tpdeq_pkg::RAW_W-1:0]    r_raw_y, n_raw_y;
    logic [tpdeq_pkg::POS_W-1:0]    r_last_x, n_last_x;
    logic [tpdeq_pkg::POS_W-1:0]    r_last_y, n_last_y;
    logic                           r_pressed, n_pressed;
    logic [tpdeq_pkg::ID_W-1:0]     r_next_id, n_next_id;

    logic                           keep;
    logic                           ev_go;
    logic                           ev_press;
    logic                           ev_valid;
    logic                           out_of_range;
    logic                           wr;
    logic                           evict;
    logic                           pos_ok;
    logic [tpdeq_pkg::POS_W-1:0]    ev_x, ev_y;
    logic [tpdeq_pkg::POS_W-1:0]    sel_x, sel_y;

    assign keep = (i_rx_byte == tpdeq_pkg::KEEP_BYTE);
    assign ev_x = r_raw_x[tpdeq_pkg::RAW_W-1:1];
    assign ev_y = r_raw_y[tpdeq_pkg::RAW_W-1:1];
    assign out_of_range = ({1'b0, ev_x} >= i_screen_width)
                       || ({1'b0, ev_y} >= i_screen_height);

    always_comb begin
        n_phase   = r_phase;
        n_raw_x   = r_raw_x;
        n_raw_y   = r_raw_y;
        ev_go     = 1'b0;
        ev_press  = 1'b0;
        ev_valid  = 1'b0;
        if (i_byte_go) begin
            if (i_rx_byte == tpdeq_pkg::START_BYTE) begin
                n_phase = tpdeq_pkg::PH_X_HI;
            end else if (i_rx_byte[7] && !keep) begin
                n_phase = tpdeq_pkg::PH_IDLE;
            end else begin
                n_phase = tpdeq_pkg::PH_IDLE;
                case (r_phase)
                    tpdeq_pkg::PH_X_HI: begin
                        n_phase = tpdeq_pkg::PH_X_LO;
                        if (!keep) n_raw_x[13:7] = i_rx_byte[6:0];
                    end
                    tpdeq_pkg::PH_X_LO: begin
                        n_phase = tpdeq_pkg::PH_Y_HI;
                        if (!keep) n_raw_x[6:0] = i_rx_byte[6:0];
                    end
                    tpdeq_pkg::PH_Y_HI: begin
                        n_phase = tpdeq_pkg::PH_Y_LO;
                        if (!keep) n_raw_y[13:7] = i_rx_byte[6:0];
                    end
                    tpdeq_pkg::PH_Y_LO: begin
                        n_phase = tpdeq_pkg::PH_PRESS;
                        if (!keep) n_raw_y[6:0] = i_rx_byte[6:0];
                    end
                    tpdeq_pkg::PH_PRESS: begin
                        // Only 0 (release) and 1 (press) complete a packet.
                        if (i_rx_byte[7:1] == 7'd0) begin
                            ev_go    = 1'b1;
                            ev_press = i_rx_byte[0];
                            ev_valid = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = tpdeq_pkg::PH_IDLE;
                    end
                endcase
            end
        end else if (i_err_go) begin
            n_phase = tpdeq_pkg::PH_IDLE;
            ev_go   = r_pressed;
        end
    end

    always_comb begin
        wr        = ev_go;
        evict     = 1'b0;
        pos_ok    = ev_valid;
        sel_x     = ev_x;
        sel_y     = ev_y;
        if (out_of_range) begin
            // Only a release of a held contact survives, at the last position.
            if (ev_press || !r_pressed) wr = 1'b0;
            sel_x  = r_last_x;
            sel_y  = r_last_y;
            pos_ok = 1'b0;
        end
        if (!ev_press && !r_pressed) wr = 1'b0;
        if (i_status.full) begin
            if (ev_press) begin
                wr = 1'b0;
            end else begin
                evict  = 1'b1;
                pos_ok = 1'b0;
            end
        end

        o_wr_req                      = '0;
        o_wr_req.wr_en                = wr;
        o_wr_req.evict                = wr && evict;
        o_wr_req.entry.touch_id       = r_next_id;
        o_wr_req.entry.pos_x          = sel_x;
        o_wr_req.entry.pos_y          = sel_y;
        o_wr_req.entry.position_valid = pos_ok;
        if (!ev_press) begin
            o_wr_req.entry.event_kind = tpdeq_pkg::KIND_UP;
        end else if (r_pressed) begin
            o_wr_req.entry.event_kind = tpdeq_pkg::KIND_MOVE;
        end else begin
            o_wr_req.entry.event_kind = tpdeq_pkg::KIND_DOWN;
        end

        n_pressed = r_pressed;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        n_next_id = r_next_id;
        if (wr) begin
            n_pressed = ev_press;
            n_last_x  = sel_x;
            n_last_y  = sel_y;
            if (!ev_press) n_next_id = r_next_id + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= tpdeq_pkg::PH_IDLE;
            r_raw_x   <= '0;
            r_raw_y   <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_pressed <= 1'b0;
            r_next_id <= '0;
        end else begin
            r_phase   <= n_phase;
            r_raw_x   <= n_raw_x;
            r_raw_y   <= n_raw_y;
            r_last_x  <= n_last_x;
            r_last_y  <= n_last_y;
            r_pressed <= n_pressed;
            r_next_id <= n_next_id;
        end
    end

endmodule

// File: sv/tpdeq_queue.sv
// Ring buffer of touch events with eviction of the oldest entry and registered read.
module tpdeq_queue #(
    parameter int QUEUE_DEPTH = tpdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tpdeq_pkg::t_wr_req    i_wr_req,
    input  logic                  i_rd_en,
    output tpdeq_pkg::t_q_status  o_status,
    output tpdeq_pkg::t_event     o_rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);

    tpdeq_pkg::t_event    r_mem [QUEUE_DEPTH];
    tpdeq_pkg::t_event    r_rd_data;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     rd_inc, wr_inc;

    assign rd_inc = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
    assign wr_inc = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;

    // One slot stays empty so that full and empty can be told apart.
    assign o_status.full  = (wr_inc == r_rd_ptr);
    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_rd_data      = r_rd_data;

    assign n_rd_ptr = (i_rd_en || i_wr_req.evict) ? rd_inc : r_rd_ptr;
    assign n_wr_ptr = i_wr_req.wr_en ? wr_inc : r_wr_ptr;

    always_ff @(posedge i_clk) begin
        if (i_wr_req.wr_en) r_mem[r_wr_ptr] <= i_wr_req.entry;
        if (i_rd_en) r_rd_data <= r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

endmodule

// File: sv/touch_packet_decoder_event_queue_core.sv
// Top level of the touch packet decoder and event queue: handshakes, settings and output stage.
// Throughput: one input transaction per cycle while o_in_stall is low; byte and line
// error commands finish in that cycle. A pop reads the event memory into the read register at the
// accepting edge; the event then moves to the output register once that is empty or being taken.
// Input is stalled only while a read event waits behind a full, stalled output register.
// Reset (synchronous, active low) empties the queue, idles the parser and restores the
// screen size; memory contents are not cleared, as no entry is read before it is written.
module touch_packet_decoder_event_queue_core #(
    parameter int QUEUE_DEPTH = tpdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_command,
    input  logic [7:0]                          i_rx_byte,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tpdeq_pkg::ID_W-1:0]          o_touch_id,
    output logic [tpdeq_pkg::POS_W-1:0]         o_pos_x,
    output logic [tpdeq_pkg::POS_W-1:0]         o_pos_y,
    output logic                                o_position_valid,
    output logic [1:0]                          o_event_kind,

    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tpdeq_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [tpdeq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Screen size registers. The port is always ready; the host writes them only while
    // no transaction is in flight, a rule on the host that the block itself does not enforce.
    logic [tpdeq_pkg::CFG_DATA_W-1:0] r_screen_width;
    logic [tpdeq_pkg::CFG_DATA_W-1:0] r_screen_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= tpdeq_pkg::SCREEN_WIDTH_RST;
            r_screen_height <= tpdeq_pkg::SCREEN_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tpdeq_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                tpdeq_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Command decode for the accepted transaction. Command 3 is simply consumed.
    tpdeq_pkg::t_cmd      cmd;
    logic                 in_take;
    logic                 byte_go;
    logic                 err_go;
    logic                 pop_go;
    tpdeq_pkg::t_wr_req   wr_req;
    tpdeq_pkg::t_q_status q_status;
    tpdeq_pkg::t_event    rd_data;

    assign cmd     = tpdeq_pkg::t_cmd'(i_command);
    assign in_take = i_in_valid && !o_in_stall;
    assign byte_go = in_take && (cmd == tpdeq_pkg::CMD_BYTE);
    assign err_go  = in_take && (cmd == tpdeq_pkg::CMD_LINE_ERR);
    // A pop of an empty queue produces nothing.
    assign pop_go  = in_take && (cmd == tpdeq_pkg::CMD_POP) && !q_status.empty;

    tpdeq_decoder u_decoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_byte_go       (byte_go),
        .i_err_go        (err_go),
        .i_rx_byte       (i_rx_byte),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_status        (q_status),
        .o_wr_req        (wr_req)
    );

    tpdeq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_req  (wr_req),
        .i_rd_en   (pop_go),
        .o_status  (q_status),
        .o_rd_data (rd_data)
    );

    // Output stage. The memory read register is the first stage; r_rd_vld marks that it
    // holds an event still to be delivered. It moves into the output register whenever
    // that register is empty or being taken. The read register only changes on a new pop,
    // so stalling input while the event cannot move is enough to keep it intact.
    logic                 r_rd_vld, n_rd_vld;
    logic                 r_out_valid, n_out_valid;
    tpdeq_pkg::t_event    r_out;
    logic                 rd_move;

    assign rd_move    = r_rd_vld && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_rd_vld && r_out_valid && i_out_stall;

    always_comb begin
        n_rd_vld = r_rd_vld;
        if (rd_move) n_rd_vld = 1'b0;
        if (pop_go)  n_rd_vld = 1'b1;

        n_out_valid = r_out_valid;
        if (!i_out_stall) n_out_valid = 1'b0;
        if (rd_move)      n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_move) r_out <= rd_data;
    end

    assign o_out_valid      = r_out_valid;
    assign o_touch_id       = r_out.touch_id;
    assign o_pos_x          = r_out.pos_x;
    assign o_pos_y          = r_out.pos_y;
    assign o_position_valid = r_out.position_valid;
    assign o_event_kind     = r_out.event_kind;

    // A read event waiting behind a stalled output must still be there in the next cycle.
    a_rd_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld && r_out_valid && i_out_stall) |=> r_rd_vld)
        else $error("pending read event lost while output stalled");

    // Only a release may evict, and it is then never marked trustworthy.
    a_evict_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.evict |-> (wr_req.wr_en && !wr_req.entry.position_valid
                          && (wr_req.entry.event_kind == tpdeq_pkg::KIND_UP)))
        else $error("eviction by something other than an invalid release");

    // A queue write and a pop never fall in the same cycle.
    a_no_wr_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_req.wr_en && pop_go))
        else $error("queue write coincides with pop");

    // A new result only appears after the read stage held one.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rd_vld))
        else $error("output became valid without a read event");

endmodule
